>>> rtl/swfte_pkg.sv
// Shared constants, types and helpers of the fill-time estimator.
package swfte_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int VAL_W        = 48;
    localparam int TPS_W        = 24;
    localparam int SEC_W        = 32;
    localparam int PROD_W       = VAL_W + TPS_W;
    localparam int NUM_W        = 2 * VAL_W;
    localparam int DSH_W        = PROD_W + SEC_W - 1;

    localparam logic [7:0] REG_WINDOW_TICKS     = 8'd0;
    localparam logic [7:0] REG_TICKS_PER_SECOND = 8'd1;

    localparam logic [VAL_W-1:0] WINDOW_TICKS_RST     = VAL_W'(1200000);
    localparam logic [TPS_W-1:0] TICKS_PER_SECOND_RST = TPS_W'(120000);

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_NUM_LO,
        MUL_NUM_HI,
        MUL_DEN
    } mul_step_t;

    typedef struct packed {
        logic      set_start;
        logic      rd_newest;
        logic      drop;
        logic      latch_old;
        mul_step_t mul_step;
        logic      num_load;
        logic      num_add;
        logic      den_load;
        logic      div_init;
        logic      div_step;
        logic      load_out;
        logic      store;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic newer;
        logic can_drop;
        logic flat;
        logic div_sat;
        logic div_last;
        logic report_due;
        logic out_free;
    } dp_status_t;

    // Wrap a ring position that is below twice the depth.
    function automatic logic [PTR_W-1:0] wrap_ptr(input logic [CNT_W:0] pos);
        logic [CNT_W:0] adj;
        begin
            adj = (pos >= (CNT_W + 1)'(WINDOW_DEPTH)) ? pos - (CNT_W + 1)'(WINDOW_DEPTH) : pos;
            wrap_ptr = adj[PTR_W-1:0];
        end
    endfunction

endpackage

>>> rtl/swfte_ctrl.sv
// Sequencer of the fill-time estimator: walks one report through its steps.
module swfte_ctrl
    import swfte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  dp_status_t status,
    output logic       idle,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_NEWEST,
        ST_HEAD,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_DIVI,
        ST_DIV,
        ST_REPORT,
        ST_STORE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign idle = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_step = MUL_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (status.count_zero)
                begin
                    cmd.set_start = 1'b1;
                    state_next    = ST_STORE;
                end
                else
                begin
                    cmd.rd_newest = 1'b1;
                    state_next    = ST_NEWEST;
                end
            end
            ST_NEWEST:
            begin
                state_next = status.newer ? ST_HEAD : ST_IDLE;
            end
            ST_HEAD:
            begin
                if (status.can_drop)
                    cmd.drop = 1'b1;
                else
                begin
                    cmd.latch_old = 1'b1;
                    state_next    = status.flat ? ST_REPORT : ST_M0;
                end
            end
            ST_M0:
            begin
                cmd.mul_step = MUL_NUM_LO;
                state_next   = ST_M1;
            end
            ST_M1:
            begin
                cmd.mul_step = MUL_NUM_HI;
                cmd.num_load = 1'b1;
                state_next   = ST_M2;
            end
            ST_M2:
            begin
                cmd.mul_step = MUL_DEN;
                cmd.num_add  = 1'b1;
                state_next   = ST_M3;
            end
            ST_M3:
            begin
                cmd.den_load = 1'b1;
                state_next   = ST_DIVI;
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = status.div_sat ? ST_REPORT : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (!status.report_due)
                    state_next = ST_STORE;
                else if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/swfte_dp.sv
// Datapath of the fill-time estimator: ring memory, multiplier, divider, output register.
module swfte_dp
    import swfte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               command,
    input  logic [VAL_W-1:0]   size_value,
    input  logic [VAL_W-1:0]   timestamp,
    input  logic [VAL_W-1:0]   free_space,
    input  logic               new_file,
    input  logic               cfg_write,
    input  logic [7:0]         cfg_index,
    input  logic [VAL_W-1:0]   cfg_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [VAL_W-1:0]   free_space_out,
    output logic [SEC_W-1:0]   secs_to_full,
    output logic               no_growth,
    output logic [VAL_W-1:0]   elapsed_ticks,
    input  dp_cmd_t            cmd,
    output dp_status_t         status
);

    logic [2*VAL_W-1:0] mem [WINDOW_DEPTH];
    logic [2*VAL_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]   rd_addr;

    logic [VAL_W-1:0]  window_reg;
    logic [TPS_W-1:0]  tps_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [VAL_W-1:0]  total_reg;
    logic [VAL_W-1:0]  start_reg;
    logic [VAL_W-1:0]  last_reg;
    logic              out_valid_reg;

    logic [VAL_W-1:0]  ts_reg;
    logic [VAL_W-1:0]  free_reg;
    logic [VAL_W-1:0]  fsize_reg;
    logic [VAL_W-1:0]  dt_reg;
    logic [VAL_W-1:0]  dsize_reg;
    logic              flat_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [PROD_W-1:0] den_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [SEC_W-1:0]  quot_reg;
    logic [4:0]        bit_reg;

    logic [VAL_W-1:0]  total_sum;
    logic [VAL_W-1:0]  rd_time;
    logic [VAL_W-1:0]  rd_size;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  newest_ptr;
    logic [PTR_W-1:0]  slot_ptr;
    logic [VAL_W-1:0]  mul_a;
    logic [TPS_W-1:0]  mul_b;
    logic [VAL_W-1:0]  since_last;
    logic [DSH_W:0]    rem_ext;
    logic              div_ge;

    assign total_sum  = total_reg + size_value;
    assign rd_time    = rd_data_reg[VAL_W-1:0];
    assign rd_size    = rd_data_reg[2*VAL_W-1:VAL_W];
    assign head_inc   = wrap_ptr((CNT_W + 1)'(head_reg) + (CNT_W + 1)'(1));
    assign newest_ptr = wrap_ptr((CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg)
                                 - (CNT_W + 1)'(1));
    assign slot_ptr   = wrap_ptr((CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg));
    assign since_last = ts_reg - last_reg;
    assign rem_ext    = (DSH_W + 1)'(rem_reg);
    assign div_ge     = rem_ext >= (DSH_W + 1)'(dsh_reg);

    always_comb
    begin
        if (cmd.rd_newest)
            rd_addr = newest_ptr;
        else if (cmd.drop)
            rd_addr = head_inc;
        else
            rd_addr = head_reg;
    end

    always_comb
    begin
        case (cmd.mul_step)
            MUL_NUM_LO:
            begin
                mul_a = free_reg;
                mul_b = dt_reg[TPS_W-1:0];
            end
            MUL_NUM_HI:
            begin
                mul_a = free_reg;
                mul_b = dt_reg[VAL_W-1:TPS_W];
            end
            MUL_DEN:
            begin
                mul_a = dsize_reg;
                mul_b = tps_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign status.count_zero = (count_reg == '0);
    assign status.newer      = ts_reg > rd_time;
    assign status.can_drop   = (count_reg > CNT_W'(1)) &&
                               (({1'b0, rd_time} + {1'b0, window_reg}) < {1'b0, ts_reg});
    assign status.flat       = fsize_reg <= rd_size;
    assign status.div_sat    = (NUM_W + SEC_W)'(num_reg) >=
                               (NUM_W + SEC_W)'({den_reg, {SEC_W{1'b0}}});
    assign status.div_last   = (bit_reg == 5'd0);
    assign status.report_due = (last_reg == '0) || (since_last >= VAL_W'(tps_reg));
    assign status.out_free   = !out_valid_reg || out_ready;

    // Ring memory: one read port, one write port, registered read.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.store)
            mem[slot_ptr] <= {fsize_reg, ts_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_TICKS_RST;
            tps_reg       <= TICKS_PER_SECOND_RST;
            head_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            start_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_WINDOW_TICKS:     window_reg <= cfg_data;
                    REG_TICKS_PER_SECOND: tps_reg    <= cfg_data[TPS_W-1:0];
                    default:              ;
                endcase
            end
            if (accept)
            begin
                if (!command)
                    total_reg <= total_sum;
                else if (new_file)
                    count_reg <= '0;
            end
            if (cmd.set_start)
                start_reg <= ts_reg;
            if (cmd.drop)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.store)
            begin
                if (count_reg == CNT_W'(WINDOW_DEPTH))
                    head_reg <= head_inc;
                else
                    count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                last_reg      <= ts_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ts_reg    <= timestamp;
            free_reg  <= free_space;
            fsize_reg <= command ? size_value : total_sum;
        end
        if (cmd.latch_old)
        begin
            dt_reg    <= ts_reg - rd_time;
            dsize_reg <= fsize_reg - rd_size;
            flat_reg  <= status.flat;
            quot_reg  <= {SEC_W{1'b1}};
        end
        prod_reg <= mul_a * mul_b;
        if (cmd.num_load)
            num_reg <= NUM_W'(prod_reg);
        if (cmd.num_add)
            num_reg <= num_reg + (NUM_W'(prod_reg) << TPS_W);
        if (cmd.den_load)
            den_reg <= prod_reg;
        if (cmd.div_init)
        begin
            rem_reg <= num_reg;
            dsh_reg <= DSH_W'(den_reg) << (SEC_W - 1);
            bit_reg <= 5'(SEC_W - 1);
            quot_reg <= status.div_sat ? {SEC_W{1'b1}} : '0;
        end
        if (cmd.div_step)
        begin
            if (div_ge)
                rem_reg <= NUM_W'(rem_ext - (DSH_W + 1)'(dsh_reg));
            quot_reg <= {quot_reg[SEC_W-2:0], div_ge};
            dsh_reg  <= dsh_reg >> 1;
            bit_reg  <= bit_reg - 5'd1;
        end
        if (cmd.load_out)
        begin
            free_space_out <= free_reg;
            secs_to_full   <= quot_reg;
            no_growth      <= flat_reg;
            elapsed_ticks  <= ts_reg - start_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("ring count beyond depth");

    a_store_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> count_reg != '0)
        else $error("ring empty after a store");

    a_drop_keeps_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |-> count_reg > CNT_W'(1))
        else $error("drop would empty the window");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

>>> rtl/sliding_window_fill_time_estimator_top.sv
// Top level of the sliding-window fill-time estimator.
// Each report walks the sequencer: it reads the newest point, drops aged-out points
// from the window head (up to 63), then runs the multiplier and the 32-step divider,
// which are skipped when the size did not grow; a report that is rejected or that
// opens a window ends early. A new report is taken only once the last one is through,
// and a result not yet taken holds the sequencer until it goes.
// Reset (rst_n, asynchronous, active low) empties the window, clears the
// running total and report history, and restores default register values.
module sliding_window_fill_time_estimator_top
    import swfte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Report channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [VAL_W-1:0]   size_value,
    input  logic [VAL_W-1:0]   timestamp,
    input  logic [VAL_W-1:0]   free_space,
    input  logic               new_file,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VAL_W-1:0]   free_space_out,
    output logic [SEC_W-1:0]   secs_to_full,
    output logic               no_growth,
    output logic [VAL_W-1:0]   elapsed_ticks,
    // Register write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [VAL_W-1:0]   cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       idle;
    logic       accept;

    // Take a new report only when the sequencer has finished the last one;
    // a result still waiting in the output register holds the sequencer at
    // its report step, and so holds off the next transfer too.
    assign in_ready  = idle;
    assign accept    = in_valid && in_ready;
    // Register writes land at once; the user must issue them only while idle, as the block itself does not enforce it.
    assign cfg_ready = 1'b1;

    swfte_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .status (status),
        .idle   (idle),
        .cmd    (cmd)
    );

    swfte_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .command        (command),
        .size_value     (size_value),
        .timestamp      (timestamp),
        .free_space     (free_space),
        .new_file       (new_file),
        .cfg_write      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .free_space_out (free_space_out),
        .secs_to_full   (secs_to_full),
        .no_growth      (no_growth),
        .elapsed_ticks  (elapsed_ticks),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench of the sliding-window fill-time estimator.
`timescale 1ns / 100ps

module tb;
    import swfte_pkg::*;

    // Result of one report, as the block presents it.
    typedef struct packed {
        logic [VAL_W-1:0] fs;
        logic [SEC_W-1:0] sec;
        logic             ng;
        logic [VAL_W-1:0] el;
    } fill_res_t;

    // How a directed row is checked: by the predictor, or by a literal value.
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NO_RESULT,
        CHK_LITERAL
    } chk_kind_t;

    typedef struct packed {
        logic             cmd;
        logic [VAL_W-1:0] sz;
        logic [VAL_W-1:0] ts;
        logic [VAL_W-1:0] fs;
        logic             nf;
        chk_kind_t        kind;
        fill_res_t        lit;
    } stim_row_t;

    localparam logic [VAL_W-1:0] MAX48 = {VAL_W{1'b1}};
    localparam logic [SEC_W-1:0] SAT32 = {SEC_W{1'b1}};
    localparam logic [TPS_W-1:0] MAX24 = {TPS_W{1'b1}};
    localparam int N_DIRECTED = 16;
    localparam int N_PHASES   = 5;
    localparam int PER_PHASE  = 80;
    localparam int SETTLE     = 200;
    localparam int FILL_DEPTH = 16;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic [VAL_W-1:0]   size_value;
    logic [VAL_W-1:0]   timestamp;
    logic [VAL_W-1:0]   free_space;
    logic               new_file;
    logic               out_valid;
    logic               out_ready;
    logic [VAL_W-1:0]   free_space_out;
    logic [SEC_W-1:0]   secs_to_full;
    logic               no_growth;
    logic [VAL_W-1:0]   elapsed_ticks;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_index;
    logic [VAL_W-1:0]   cfg_data;

    // Check mode and literal of the item on the bus; held with the payload.
    chk_kind_t          cur_kind;
    fill_res_t          cur_lit;

    sliding_window_fill_time_estimator_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .size_value     (size_value),
        .timestamp      (timestamp),
        .free_space     (free_space),
        .new_file       (new_file),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .free_space_out (free_space_out),
        .secs_to_full   (secs_to_full),
        .no_growth      (no_growth),
        .elapsed_ticks  (elapsed_ticks),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the window, totals and registers.
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] win_ticks;
    logic [TPS_W-1:0] tick_rate;
    logic [VAL_W-1:0] pt_time [WINDOW_DEPTH];
    logic [VAL_W-1:0] pt_size [WINDOW_DEPTH];
    int               oldest;
    int               npoints;
    logic [VAL_W-1:0] byte_total;
    logic [VAL_W-1:0] file_t0;
    logic [VAL_W-1:0] last_rep_t;

    // Expected results in arrival order: a small ring with write and read counts.
    fill_res_t        fill_buf [FILL_DEPTH];
    int               fill_wr;
    int               fill_rd;
    int               n_errors;
    int               n_items;
    int               n_results;
    int               n_settings;

    // Work out the fill-time report that one accepted write report causes.
    task automatic estimate_fill(input logic cmd, input logic [VAL_W-1:0] sz,
                                 input logic [VAL_W-1:0] ts, input logic [VAL_W-1:0] fs,
                                 input logic nf, output bit got, output fill_res_t res);
        logic [VAL_W-1:0] fsize;
        logic [VAL_W-1:0] dt;
        logic [127:0]     num;
        logic [127:0]     den;
        logic [127:0]     quo;
        int               slot;
        begin
            got = 1'b0;
            res = '0;
            if (!cmd)
            begin
                byte_total = byte_total + sz;
                fsize = byte_total;
            end
            else
            begin
                if (nf)
                    npoints = 0;
                fsize = sz;
            end
            if (npoints == 0)
                file_t0 = ts;
            else if (ts <= pt_time[(oldest + npoints - 1) % WINDOW_DEPTH])
                return;
            // Drop points that have aged out, always keeping at least one point.
            while (npoints > 1 &&
                   ({1'b0, pt_time[oldest]} + {1'b0, win_ticks}) < {1'b0, ts})
            begin
                oldest  = (oldest + 1) % WINDOW_DEPTH;
                npoints = npoints - 1;
            end
            if (npoints > 0)
            begin
                res.fs = fs;
                res.el = ts - file_t0;
                if (fsize <= pt_size[oldest])
                begin
                    res.ng  = 1'b1;
                    res.sec = SAT32;
                end
                else
                begin
                    dt  = ts - pt_time[oldest];
                    num = 128'(fs) * 128'(dt);
                    den = 128'(fsize - pt_size[oldest]) * 128'(tick_rate);
                    res.ng = 1'b0;
                    if (den == 0 || num >= (den << 32))
                        res.sec = SAT32;
                    else
                    begin
                        quo     = num / den;
                        res.sec = quo[SEC_W-1:0];
                    end
                end
                if (last_rep_t == 0 || VAL_W'(ts - last_rep_t) >= VAL_W'(tick_rate))
                begin
                    last_rep_t = ts;
                    got = 1'b1;
                end
            end
            if (npoints == WINDOW_DEPTH)
            begin
                oldest  = (oldest + 1) % WINDOW_DEPTH;
                npoints = npoints - 1;
            end
            slot = (oldest + npoints) % WINDOW_DEPTH;
            pt_time[slot] = ts;
            pt_size[slot] = fsize;
            npoints = npoints + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: follow register writes and accepted reports, check results.
    // One process, so prediction and comparison never race each other.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit        got;
        fill_res_t res;
        fill_res_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_WINDOW_TICKS)
                    win_ticks = cfg_data;
                else if (cfg_index == REG_TICKS_PER_SECOND)
                    tick_rate = cfg_data[TPS_W-1:0];
            end
            if (in_valid && in_ready)
            begin
                n_items++;
                estimate_fill(command, size_value, timestamp, free_space, new_file, got, res);
                if (cur_kind == CHK_LITERAL)
                begin
                    fill_buf[fill_wr % FILL_DEPTH] = cur_lit;
                    fill_wr++;
                end
                else if (cur_kind == CHK_PREDICT && got)
                begin
                    fill_buf[fill_wr % FILL_DEPTH] = res;
                    fill_wr++;
                end
            end
            if (out_valid && out_ready)
            begin
                n_results++;
                if (fill_wr == fill_rd)
                begin
                    n_errors++;
                    $display("%0t: unexpected result transfer, secs_to_full %0d",
                             $realtime, secs_to_full);
                end
                else
                begin
                    want = fill_buf[fill_rd % FILL_DEPTH];
                    fill_rd++;
                    if (free_space_out !== want.fs)
                    begin
                        n_errors++;
                        $display("%0t: free_space_out expected %0d actual %0d",
                                 $realtime, want.fs, free_space_out);
                    end
                    if (secs_to_full !== want.sec)
                    begin
                        n_errors++;
                        $display("%0t: secs_to_full expected %0d actual %0d",
                                 $realtime, want.sec, secs_to_full);
                    end
                    if (no_growth !== want.ng)
                    begin
                        n_errors++;
                        $display("%0t: no_growth expected %0d actual %0d",
                                 $realtime, want.ng, no_growth);
                    end
                    if (elapsed_ticks !== want.el)
                    begin
                        n_errors++;
                        $display("%0t: elapsed_ticks expected %0d actual %0d",
                                 $realtime, want.el, elapsed_ticks);
                    end
                end
            end
        end
    end

    // Receiver: free flow, random stalls, light stalls and long stalls in turn.
    int unsigned rx_cycle;
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[10:9])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= 1'($urandom_range(0, 1));
            2'd2:    out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= (rx_cycle[3:0] == 4'd0);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    int burst_left;

    function automatic logic [VAL_W-1:0] rand48();
        logic [63:0] v;
        begin
            v = {$urandom, $urandom};
            rand48 = v[VAL_W-1:0] >> $urandom_range(0, VAL_W - 1);
        end
    endfunction

    // Present one report and hold it until the transfer; then maybe idle.
    task automatic send_report(input logic cmd, input logic [VAL_W-1:0] sz,
                               input logic [VAL_W-1:0] ts, input logic [VAL_W-1:0] fs,
                               input logic nf, input chk_kind_t kind, input fill_res_t lit);
        begin
            command    <= cmd;
            size_value <= sz;
            timestamp  <= ts;
            free_space <= fs;
            new_file   <= nf;
            cur_kind   <= kind;
            cur_lit    <= lit;
            in_valid   <= 1'b1;
            do @(negedge clk); while (!in_ready);
            @(posedge clk);
            if (burst_left > 0)
                burst_left--;
            else
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 25)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
            end
        end
    endtask

    // Wait until every expected result is in and the block has gone quiet.
    task automatic drain();
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while (fill_wr != fill_rd);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    // Present one register write and hold it until the transfer.
    task automatic write_reg(input logic [7:0] idx, input logic [VAL_W-1:0] val);
        begin
            cfg_index <= idx;
            cfg_data  <= val;
            cfg_valid <= 1'b1;
            do @(negedge clk); while (!cfg_ready);
            @(posedge clk);
        end
    endtask

    stim_row_t dir_tab [N_DIRECTED];
    logic [VAL_W-1:0] ph_window [N_PHASES];
    logic [TPS_W-1:0] ph_rate   [N_PHASES];

    initial
    begin
        logic [VAL_W-1:0] last_ts;
        logic [VAL_W-1:0] cur_size;
        logic [VAL_W-1:0] step_max;
        logic [VAL_W-1:0] ts;
        logic [VAL_W-1:0] sz;
        logic             cmd;
        logic             nf;
        int               nf_odds;
        fill_res_t        lit0;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = 1'b0;
        size_value = '0;
        timestamp  = '0;
        free_space = '0;
        new_file   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        out_ready  = 1'b0;
        rx_cycle   = 0;
        cur_kind   = CHK_PREDICT;
        cur_lit    = '0;
        burst_left = 0;
        n_errors   = 0;
        n_items    = 0;
        n_results  = 0;
        n_settings = 1;
        win_ticks  = WINDOW_TICKS_RST;
        tick_rate  = TICKS_PER_SECOND_RST;
        oldest     = 0;
        npoints    = 0;
        byte_total = '0;
        file_t0    = '0;
        last_rep_t = '0;
        lit0       = '0;

        // Directed rows under the reset register values.
        dir_tab = '{
            // first point of a new file: stored, no report
            '{1'b1, 48'd100, 48'd1000, 48'd5000, 1'b1, CHK_NO_RESULT, lit0},
            // flat size, never reported yet: saturated, no growth
            '{1'b1, 48'd100, 48'd2000, 48'd5000, 1'b0, CHK_LITERAL,
              '{48'd5000, SAT32, 1'b1, 48'd1000}},
            // timestamp going backwards, then repeating: dropped
            '{1'b1, 48'd50, 48'd1500, 48'd5000, 1'b0, CHK_NO_RESULT, lit0},
            '{1'b1, 48'd50, 48'd2000, 48'd5000, 1'b0, CHK_NO_RESULT, lit0},
            // delta with the new-file flag: flag ignored
            '{1'b0, 48'd0, 48'd3000, 48'd0, 1'b1, CHK_PREDICT, lit0},
            '{1'b0, 48'd1000, 48'd200000, 48'd1000000, 1'b0, CHK_PREDICT, lit0},
            '{1'b1, MAX48, 48'd400000, MAX48, 1'b0, CHK_PREDICT, lit0},
            // running total wraps
            '{1'b0, MAX48, 48'd600000, 48'd12345, 1'b0, CHK_PREDICT, lit0},
            '{1'b0, MAX48, 48'd800000, MAX48, 1'b0, CHK_PREDICT, lit0},
            // new file at time zero, then a report just after it
            '{1'b1, 48'd0, 48'd0, 48'd0, 1'b1, CHK_NO_RESULT, lit0},
            '{1'b1, 48'd1, 48'd1, MAX48, 1'b0, CHK_PREDICT, lit0},
            // far past the window: old points drop
            '{1'b1, 48'd2, 48'd5000000, 48'd777, 1'b0, CHK_PREDICT, lit0},
            // timestamps at the top of the range
            '{1'b1, 48'd10, MAX48 - 48'd1, MAX48, 1'b1, CHK_NO_RESULT, lit0},
            '{1'b1, 48'd20, MAX48, MAX48, 1'b0, CHK_PREDICT, lit0},
            '{1'b1, 48'd0, 48'd0, 48'd0, 1'b1, CHK_NO_RESULT, lit0},
            '{1'b1, 48'd5, 48'd120000, 48'd0, 1'b0, CHK_PREDICT, lit0}
        };

        // Settings per random phase, the extremes among them.
        ph_window = '{MAX48, 48'd1, 48'd1000, 48'd0, WINDOW_TICKS_RST};
        ph_rate   = '{24'd1, MAX24, 24'd37, 24'd0, TICKS_PER_SECOND_RST};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        foreach (dir_tab[i])
            send_report(dir_tab[i].cmd, dir_tab[i].sz, dir_tab[i].ts, dir_tab[i].fs,
                        dir_tab[i].nf, dir_tab[i].kind, dir_tab[i].lit);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            // A zero entry in the phase table stands for a random setting.
            write_reg(REG_WINDOW_TICKS,
                      (ph_window[ph] == 0) ? 48'($urandom_range(1, 500000)) : ph_window[ph]);
            write_reg(REG_TICKS_PER_SECOND,
                      (ph_rate[ph] == 0) ? 48'($urandom_range(1, 5000)) : 48'(ph_rate[ph]));
            cfg_valid <= 1'b0;
            n_settings++;
            step_max = (ph_rate[ph] == 0) ? 48'd10000 : 48'(ph_rate[ph]) * 2;
            nf_odds  = (ph == 0) ? 200 : 30;
            last_ts  = 48'd100;
            cur_size = '0;
            // Open the phase with a fresh file so the window starts clean.
            send_report(1'b1, 48'd0, last_ts, rand48(), 1'b1, CHK_PREDICT, lit0);
            for (int k = 0; k < PER_PHASE; k++)
            begin
                cmd = 1'($urandom_range(0, 1));
                nf  = 1'b0;
                ts  = last_ts + 48'($urandom_range(1, 1000)) +
                      (step_max > 1 ? 48'($urandom) % step_max : 48'd0);
                if ($urandom_range(0, 19) == 0)
                    ts = last_ts - 48'($urandom_range(0, 50));
                if ($urandom_range(1, nf_odds) == 1 || last_ts > (MAX48 >> 1))
                begin
                    cmd = 1'b1;
                    nf  = 1'b1;
                    ts  = ($urandom_range(0, 3) == 0) ? rand48() : 48'($urandom);
                end
                case ($urandom_range(0, 5))
                    0:       sz = '0;
                    1:       sz = rand48();
                    default: sz = 48'($urandom_range(0, 100000));
                endcase
                if (cmd)
                begin
                    cur_size = ($urandom_range(0, 3) == 0) ? sz : cur_size + sz;
                    sz = cur_size;
                end
                else
                    nf = 1'($urandom_range(0, 1));
                send_report(cmd, sz, ts, rand48(), nf, CHK_PREDICT, lit0);
                if (nf && cmd)
                    last_ts = ts;
                else if (ts > last_ts)
                    last_ts = ts;
            end
        end
        drain();

        $display("Covered %0d reports and %0d results over %0d register settings.",
                 n_items, n_results, n_settings);
        $display("Directed edge cases, wrapping totals, full window and rate limits.");
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
